### hdl/tlt_pkg.sv
`default_nettype none

package tlt_pkg;

  // default limits on counted lengths
  localparam int unsigned TLT_MAX_WORD_LENGTH    = 255;
  localparam int unsigned TLT_MAX_COMMENT_LENGTH = 65535;

  // entries in the queue between front and back, a power of two
  localparam int unsigned TLT_QUEUE_DEPTH = 4;
  localparam int unsigned TLT_QUEUE_AW    = $clog2(TLT_QUEUE_DEPTH);

  localparam int unsigned TLT_LEN_W = 16;

  typedef enum logic [3:0] {
    KIND_KEYWORD  = 4'd0,
    KIND_CONSTANT = 4'd1,
    KIND_IDENT    = 4'd2,
    KIND_INVALID  = 4'd3,
    KIND_SYMBOL   = 4'd4,
    KIND_OPERATOR = 4'd5,
    KIND_END      = 4'd6,
    KIND_LINE_CMT = 4'd7,
    KIND_BLK_CMT  = 4'd8
  } token_kind_e;

  typedef enum logic [2:0] {
    KW_INT   = 3'd0,
    KW_IF    = 3'd1,
    KW_THEN  = 3'd2,
    KW_ELSE  = 3'd3,
    KW_ENDIF = 3'd4
  } kw_id_e;

  // characters with a role of their own
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NONE   = 8'h00;

  localparam int unsigned KW_COUNT = 5;
  localparam int unsigned KW_MAXLEN = 5;

  // keyword spelling, zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00},  // int
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},  // if
    '{8'h74, 8'h68, 8'h65, 8'h6e, 8'h00},  // then
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00},  // else
    '{8'h65, 8'h6e, 8'h64, 8'h69, 8'h66}   // endif
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd4, 3'd4, 3'd5};

  typedef struct packed {
    token_kind_e           kind;
    kw_id_e                kw;
    logic [7:0]            punct;
    logic [TLT_LEN_W-1:0]  len;
    logic                  ovf;
  } token_t;

  // what one input item leaves for the back end
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } entry_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (k < 3'(KW_COUNT) && pos < 3'(KW_MAXLEN)) begin
      ch = KW_TEXT[k][pos];
    end
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  // : , ; ( ) { }
  function automatic logic is_symbol(input logic [7:0] c);
    return c inside {8'h3a, 8'h2c, 8'h3b, 8'h28, 8'h29, 8'h7b, 8'h7d};
  endfunction

  // + - * = > [ ]
  function automatic logic is_operator(input logic [7:0] c);
    return c inside {8'h2b, 8'h2d, 8'h2a, 8'h3d, 8'h3e, 8'h5b, 8'h5d};
  endfunction

  function automatic token_t make_tok(input token_kind_e kind, input kw_id_e kw,
                                      input logic [7:0] punct,
                                      input logic [TLT_LEN_W-1:0] len, input logic ovf);
    token_t t;
    t.kind  = kind;
    t.kw    = kw;
    t.punct = punct;
    t.len   = len;
    t.ovf   = ovf;
    return t;
  endfunction

endpackage

`default_nettype wire

### hdl/tlt_front.sv
`default_nettype none

module tlt_front import tlt_pkg::*; #(
  parameter int unsigned MAX_WORD_LENGTH    = TLT_MAX_WORD_LENGTH,
  parameter int unsigned MAX_COMMENT_LENGTH = TLT_MAX_COMMENT_LENGTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] char_code_i,
  input  logic       q_full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  localparam logic [TLT_LEN_W-1:0] WORD_LIMIT = TLT_LEN_W'(MAX_WORD_LENGTH);
  localparam logic [TLT_LEN_W-1:0] CMT_LIMIT  = TLT_LEN_W'(MAX_COMMENT_LENGTH);

  typedef enum logic [4:0] {
    MODE_NORMAL     = 5'b00001,
    MODE_SLASH      = 5'b00010,
    MODE_LINE       = 5'b00100,
    MODE_BLOCK      = 5'b01000,
    MODE_BLOCK_STAR = 5'b10000
  } lex_mode_e;

  lex_mode_e              mode_q, mode_d;
  logic [TLT_LEN_W-1:0]   wcnt_q, wcnt_d;
  logic                   first_dig_q, first_dig_d;
  logic                   all_dig_q, all_dig_d;
  logic                   all_aln_q, all_aln_d;
  logic [KW_COUNT-1:0]    alive_q, alive_d;
  logic [TLT_LEN_W-1:0]   ccnt_q, ccnt_d;
  logic                   sat_q, sat_d;

  logic                   accept;
  logic                   eol;
  logic [7:0]             c;
  logic                   c_space, c_slash, c_star, c_sym, c_op, c_end, c_punct, delim;
  logic                   word_live;
  logic                   kw_found;
  kw_id_e                 kw_sel;
  token_kind_e            wkind, pkind;
  token_t                 w_tok, p_tok, div_tok, zero_tok;
  logic [TLT_LEN_W-1:0]   cc_inc;
  logic                   cc_sat;
  logic                   pre_div, run_char;
  logic [1:0]             n;
  token_t                 t0, t1;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign eol        = action_i;
  assign c          = char_code_i;

  // character classes
  assign c_space = (c == CH_SPACE);
  assign c_slash = (c == CH_SLASH);
  assign c_star  = (c == CH_STAR);
  assign c_sym   = is_symbol(c);
  assign c_op    = is_operator(c);
  assign c_end   = (c == CH_DOLLAR);
  assign c_punct = c_sym || c_op || c_end;
  assign delim   = c_space || c_slash || c_punct;

  // classify the word held so far
  always_comb begin
    kw_found = 1'b0;
    kw_sel   = KW_INT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!kw_found && !sat_q && alive_q[k] && wcnt_q == TLT_LEN_W'(KW_LEN[k])) begin
        kw_found = 1'b1;
        kw_sel   = kw_id_e'(3'(k));
      end
    end
    if (kw_found) begin
      wkind = KIND_KEYWORD;
    end else if (first_dig_q && all_dig_q) begin
      wkind = KIND_CONSTANT;
    end else if (!first_dig_q && all_aln_q) begin
      wkind = KIND_IDENT;
    end else begin
      wkind = KIND_INVALID;
    end
  end

  assign word_live = (wcnt_q != '0);
  assign w_tok     = make_tok(wkind, kw_sel, CH_NONE, wcnt_q, sat_q);

  always_comb begin
    if (c_sym) begin
      pkind = KIND_SYMBOL;
    end else if (c_op) begin
      pkind = KIND_OPERATOR;
    end else begin
      pkind = KIND_END;
    end
  end

  assign p_tok    = make_tok(pkind, KW_INT, c, '0, 1'b0);
  assign div_tok  = make_tok(KIND_OPERATOR, KW_INT, CH_SLASH, '0, 1'b0);
  assign zero_tok = make_tok(KIND_KEYWORD, KW_INT, CH_NONE, '0, 1'b0);

  // comment length, saturating
  assign cc_inc = (ccnt_q < CMT_LIMIT) ? ccnt_q + 1'b1 : ccnt_q;
  assign cc_sat = (ccnt_q < CMT_LIMIT) ? sat_q : 1'b1;

  // next lexer state and the tokens of this beat
  always_comb begin
    mode_d      = mode_q;
    wcnt_d      = wcnt_q;
    first_dig_d = first_dig_q;
    all_dig_d   = all_dig_q;
    all_aln_d   = all_aln_q;
    alive_d     = alive_q;
    ccnt_d      = ccnt_q;
    sat_d       = sat_q;
    pre_div     = 1'b0;
    run_char    = 1'b0;
    n           = 2'd0;
    t0          = zero_tok;
    t1          = zero_tok;

    case (mode_q)
      MODE_SLASH: begin
        if (eol) begin
          t0     = div_tok;
          n      = 2'd1;
          mode_d = MODE_NORMAL;
        end else if (c_slash || c_star) begin
          mode_d = c_slash ? MODE_LINE : MODE_BLOCK;
          ccnt_d = TLT_LEN_W'(2);
          sat_d  = 1'b0;
        end else begin
          pre_div  = 1'b1;
          run_char = 1'b1;
          mode_d   = MODE_NORMAL;
        end
      end
      MODE_LINE: begin
        if (eol) begin
          t0     = make_tok(KIND_LINE_CMT, KW_INT, CH_NONE, ccnt_q, sat_q);
          n      = 2'd1;
          ccnt_d = '0;
          sat_d  = 1'b0;
          mode_d = MODE_NORMAL;
        end else begin
          ccnt_d = cc_inc;
          sat_d  = cc_sat;
        end
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (eol) begin
          mode_d = MODE_BLOCK;
        end else begin
          ccnt_d = cc_inc;
          sat_d  = cc_sat;
          if (mode_q == MODE_BLOCK_STAR && c_slash) begin
            t0     = make_tok(KIND_BLK_CMT, KW_INT, CH_NONE, cc_inc, cc_sat);
            n      = 2'd1;
            ccnt_d = '0;
            sat_d  = 1'b0;
            mode_d = MODE_NORMAL;
          end else begin
            mode_d = c_star ? MODE_BLOCK_STAR : MODE_BLOCK;
          end
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
        if (eol) begin
          if (word_live) begin
            t0 = w_tok;
            n  = 2'd1;
          end
          wcnt_d      = '0;
          first_dig_d = 1'b0;
          all_dig_d   = 1'b1;
          all_aln_d   = 1'b1;
          alive_d     = '1;
          sat_d       = 1'b0;
        end else begin
          run_char = 1'b1;
        end
      end
    endcase

    // one ordinary character of the line
    if (run_char) begin
      if (delim) begin
        wcnt_d      = '0;
        first_dig_d = 1'b0;
        all_dig_d   = 1'b1;
        all_aln_d   = 1'b1;
        alive_d     = '1;
        sat_d       = 1'b0;
        if (c_slash) begin
          mode_d = MODE_SLASH;
        end
      end else begin
        if (wcnt_q == '0) begin
          first_dig_d = is_digit(c);
        end
        all_dig_d = all_dig_q && is_digit(c);
        all_aln_d = all_aln_q && is_alnum(c);
        for (int k = 0; k < KW_COUNT; k++) begin
          alive_d[k] = alive_q[k] && (wcnt_q < TLT_LEN_W'(KW_LEN[k])) &&
                       (kw_char(3'(k), wcnt_q[2:0]) == c);
        end
        if (wcnt_q < WORD_LIMIT) begin
          wcnt_d = wcnt_q + 1'b1;
        end else begin
          sat_d = 1'b1;
        end
      end

      // pack pending slash, finished word and mark in that order
      if (pre_div) begin
        t0 = div_tok;
        t1 = p_tok;
        n  = c_punct ? 2'd2 : 2'd1;
      end else if (word_live && delim) begin
        t0 = w_tok;
        t1 = p_tok;
        n  = c_punct ? 2'd2 : 2'd1;
      end else begin
        t0 = p_tok;
        n  = c_punct ? 2'd1 : 2'd0;
      end
    end
  end

  assign push_o       = accept && (n != 2'd0);
  assign entry_o.tok0 = t0;
  assign entry_o.tok1 = t1;
  assign entry_o.two  = (n == 2'd2);

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      wcnt_q      <= '0;
      first_dig_q <= 1'b0;
      all_dig_q   <= 1'b1;
      all_aln_q   <= 1'b1;
      alive_q     <= '1;
      ccnt_q      <= '0;
      sat_q       <= 1'b0;
    end else if (accept) begin
      mode_q      <= mode_d;
      wcnt_q      <= wcnt_d;
      first_dig_q <= first_dig_d;
      all_dig_q   <= all_dig_d;
      all_aln_q   <= all_aln_d;
      alive_q     <= alive_d;
      ccnt_q      <= ccnt_d;
      sat_q       <= sat_d;
    end
  end

endmodule

`default_nettype wire

### hdl/tlt_queue.sv
`default_nettype none

module tlt_queue import tlt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t                  mem_q [TLT_QUEUE_DEPTH];
  logic [TLT_QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [TLT_QUEUE_AW:0]   cnt_q;
  logic                    do_push, do_pop;

  assign full_o  = (cnt_q == (TLT_QUEUE_AW+1)'(TLT_QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/tlt_back.sv
`default_nettype none

module tlt_back import tlt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  entry_t head_i,
  input  logic   empty_i,
  output logic   pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output token_t tok_o,
  output logic   last_o
);

  logic   vld_q;
  logic   sel_q;
  token_t tok_q;
  logic   last_q;
  logic   load;
  logic   cur_last;
  token_t cur_tok;

  // pick the next token of the head entry
  assign cur_tok  = sel_q ? head_i.tok1 : head_i.tok0;
  assign cur_last = sel_q || !head_i.two;
  assign load     = !empty_i && (!vld_q || out_ready_i);
  assign pop_o    = load && cur_last;

  // output beat control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sel_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
      sel_q <= !cur_last;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      tok_q  <= cur_tok;
      last_q <= cur_last;
    end
  end

  assign out_valid_o = vld_q;
  assign tok_o       = tok_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

### hdl/toy_language_tokenizer.sv
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------------
// input    | in        | in_valid_i / in_ready_o    | action_i, char_code_i
// token    | out       | out_valid_o / out_ready_i  | token_kind_o, keyword_id_o, punct_char_o,
//          |           |                            | token_length_o, length_overflow_o,
//          |           |                            | last_of_run_o
//
// One character or end-of-line beat is taken per clock while the four-entry
// queue has room; its first token is written to the queue and then loaded into the output register.
// A beat yields zero to two tokens and the output register drains one token per
// clock while out_ready_i is high, so beats that give two tokens can fill the queue faster than it drains.
// Reset puts the lexer in plain text with no word, comment or slash pending.
// A stalled output fills the queue and then holds in_ready_o low until the clock
// after an entry is freed.

module toy_language_tokenizer import tlt_pkg::*; #(
  parameter int unsigned MAX_WORD_LENGTH    = TLT_MAX_WORD_LENGTH,
  parameter int unsigned MAX_COMMENT_LENGTH = TLT_MAX_COMMENT_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [2:0]  keyword_id_o,
  output logic [7:0]  punct_char_o,
  output logic [15:0] token_length_o,
  output logic        length_overflow_o,
  output logic        last_of_run_o
);

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_in, q_head;
  token_t tok;

  tlt_front #(
    .MAX_WORD_LENGTH   (MAX_WORD_LENGTH),
    .MAX_COMMENT_LENGTH(MAX_COMMENT_LENGTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .char_code_i(char_code_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  tlt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  tlt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .tok_o      (tok),
    .last_o     (last_of_run_o)
  );

  assign token_kind_o      = tok.kind;
  assign keyword_id_o      = tok.kw;
  assign punct_char_o      = tok.punct;
  assign token_length_o    = tok.len;
  assign length_overflow_o = tok.ovf;

endmodule

`default_nettype wire

### hdl/tlt_checker.sv
`default_nettype none

module tlt_checker import tlt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        action_i,
  input logic [7:0]  char_code_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_o,
  input logic [2:0]  keyword_id_o,
  input logic [7:0]  punct_char_o,
  input logic [15:0] token_length_o,
  input logic        length_overflow_o,
  input logic        last_of_run_o
);

  logic punct_kind;
  assign punct_kind = (token_kind_o == KIND_SYMBOL) || (token_kind_o == KIND_OPERATOR) ||
                      (token_kind_o == KIND_END);

  // a stalled token beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(token_length_o) && $stable(punct_char_o) && $stable(last_of_run_o))
    else $error("token beat changed while stalled");

  // kind codes stay in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= 4'(KIND_BLK_CMT))
    else $error("token kind out of range");

  // marks carry no length
  a_mark_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && punct_kind |-> token_length_o == '0 && !length_overflow_o &&
      punct_char_o != CH_NONE)
    else $error("mark token with length or without character");

  // keywords are short and never saturated
  a_kw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_KEYWORD |-> token_length_o >= 16'd2 &&
      token_length_o <= 16'd5 && !length_overflow_o && punct_char_o == CH_NONE)
    else $error("keyword token with bad length");

  // keyword id only on keywords
  a_kw_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_KEYWORD |-> keyword_id_o == KW_INT)
    else $error("keyword id on a non-keyword token");

endmodule

bind toy_language_tokenizer tlt_checker u_tlt_checker (.*);

`default_nettype wire
